// ===== hdl/brb_pkg.sv =====
// Shared constants and types for the byte ring buffer with peek and find.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_GET    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_FIND   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/brb_mem.sv =====
// Byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module brb_mem (
  input  wire logic              clk,
  input  wire brb_pkg::mem_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0] mem [brb_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/brb_wrap_unit.sv =====
// Shared modular pointer adder: base plus step, wrapped at capacity.
`timescale 1ns / 1ps
`default_nettype none

module brb_wrap_unit (
  input  wire logic [brb_pkg::PTR_W-1:0] base,
  input  wire logic [brb_pkg::CNT_W-1:0] step,
  input  wire logic [brb_pkg::CNT_W-1:0] cap,
  output logic      [brb_pkg::PTR_W-1:0] sum
);

  logic [brb_pkg::CNT_W:0] raw;
  logic [brb_pkg::CNT_W:0] red;

  always_comb begin
    raw = {2'b00, base} + {1'b0, step};
    red = raw - {1'b0, cap};
    if (raw >= {1'b0, cap}) begin
      sum = red[brb_pkg::PTR_W-1:0];
    end else begin
      sum = raw[brb_pkg::PTR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/byte_ring_buffer_with_peek_find_unit.sv =====
// Top level: byte ring buffer with put, get, peek, delete, find and clear.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low; its result appears for
// exactly one cycle with done high and cannot be held off. Put, delete, clear,
// unused actions and a get or peek that fails finish in the execute state; a
// get or peek that returns a byte goes on through a read state because of the
// registered read of the byte store, and find steps through a read state and
// a compare state for each byte it scans (one store read and one compare per
// byte, stepped through the shared wrap adder). busy drops in the done cycle,
// so a new item can be taken there. fill_level, is_empty and is_full always
// show the current state. The store needs no clearing pass.
// A capacity write (cfg_valid and cfg_ready) empties the buffer.
module byte_ring_buffer_with_peek_find_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [12:0] offset_or_count,
  output logic             done,
  output logic [1:0]       status,
  output logic [7:0]       read_byte,
  output logic [12:0]      found_position,
  output logic [12:0]      fill_level,
  output logic             is_empty,
  output logic             is_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_FIND_RD  = 3'd3;
  localparam logic [2:0] S_FIND_CMP = 3'd4;

  localparam int unsigned PW = brb_pkg::PTR_W;
  localparam int unsigned CW = brb_pkg::CNT_W;

  logic [2:0]    state;
  logic [CW-1:0] cap;
  logic [CW-1:0] cap_next;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] level;
  logic [PW-1:0] idx;
  logic [CW-1:0] pos;
  logic [2:0]    act_r;
  logic [7:0]    data_r;
  logic [CW-1:0] arg_r;

  logic [PW-1:0] u_base;
  logic [CW-1:0] u_step;
  logic [PW-1:0] u_sum;

  brb_pkg::mem_req_t mreq;
  logic [7:0]        rdata;

  brb_wrap_unit u_wrap (
    .base (u_base),
    .step (u_step),
    .cap  (cap),
    .sum  (u_sum)
  );

  brb_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign busy           = (state != S_IDLE);
  assign cfg_ready      = (state == S_IDLE);
  assign fill_level     = level;
  assign is_empty       = (level == '0);
  assign is_full        = (level == cap);

  always_comb begin
    priority if (cfg_data == '0) begin
      cap_next = CW'(1);
    end else if (cfg_data > CW'(brb_pkg::DEPTH)) begin
      cap_next = CW'(brb_pkg::DEPTH);
    end else begin
      cap_next = cfg_data;
    end
  end

  always_comb begin
    u_base = rp;
    u_step = CW'(1);
    if (state == S_FIND_CMP) begin
      u_base = idx;
    end else if (act_r == brb_pkg::ACT_PUT) begin
      u_base = wp;
    end else if (act_r == brb_pkg::ACT_PEEK || act_r == brb_pkg::ACT_DELETE) begin
      u_step = arg_r;
    end
  end

  always_comb begin
    mreq.we    = (state == S_EXEC) && (act_r == brb_pkg::ACT_PUT) && (level != cap);
    mreq.waddr = wp;
    mreq.wdata = data_r;
    if (state == S_FIND_RD) begin
      mreq.raddr = idx;
    end else if (act_r == brb_pkg::ACT_PEEK) begin
      mreq.raddr = u_sum;
    end else begin
      mreq.raddr = rp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= CW'(brb_pkg::DEPTH);
      wp    <= '0;
      rp    <= '0;
      level <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            cap   <= cap_next;
            wp    <= '0;
            rp    <= '0;
            level <= '0;
          end
          if (start) begin
            act_r  <= action;
            data_r <= data_byte;
            arg_r  <= offset_or_count;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          status         <= brb_pkg::ST_OK;
          read_byte      <= '0;
          found_position <= '0;
          state          <= S_IDLE;
          done           <= 1'b1;
          unique case (act_r)
            brb_pkg::ACT_PUT: begin
              if (level == cap) begin
                status <= brb_pkg::ST_FULL;
              end else begin
                wp    <= u_sum;
                level <= level + CW'(1);
              end
            end
            brb_pkg::ACT_GET: begin
              if (level == '0) begin
                status <= brb_pkg::ST_NONE;
              end else begin
                done  <= 1'b0;
                state <= S_READ;
                if (level == CW'(1)) begin
                  wp    <= '0;
                  rp    <= '0;
                  level <= '0;
                end else begin
                  rp    <= u_sum;
                  level <= level - CW'(1);
                end
              end
            end
            brb_pkg::ACT_PEEK: begin
              if (arg_r >= level) begin
                status <= brb_pkg::ST_NONE;
              end else begin
                done  <= 1'b0;
                state <= S_READ;
              end
            end
            brb_pkg::ACT_DELETE: begin
              if (arg_r == '0) begin
                level <= level;
              end else if (arg_r >= level) begin
                wp    <= '0;
                rp    <= '0;
                level <= '0;
              end else begin
                rp    <= u_sum;
                level <= level - arg_r;
              end
            end
            brb_pkg::ACT_FIND: begin
              if (level == '0) begin
                status <= brb_pkg::ST_NONE;
              end else begin
                idx   <= rp;
                pos   <= CW'(1);
                done  <= 1'b0;
                state <= S_FIND_RD;
              end
            end
            brb_pkg::ACT_CLEAR: begin
              wp    <= '0;
              rp    <= '0;
              level <= '0;
            end
            default: begin
              level <= level;
            end
          endcase
        end
        S_READ: begin
          read_byte <= rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_FIND_RD: begin
          state <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          priority if (rdata == data_r) begin
            found_position <= pos;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (pos == level) begin
            status <= brb_pkg::ST_NONE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            idx   <= u_sum;
            pos   <= pos + CW'(1);
            state <= S_FIND_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    level <= cap)
    else $error("fill level above capacity");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(is_empty && is_full))
    else $error("empty and full at once");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> is_empty)
    else $error("capacity write did not empty the buffer");

endmodule

`default_nettype wire
